/* sv/tsrp_pkg.sv */
// tsrp_pkg: shared types, phase and status codes and the key length table
// for the sensor record parser; no dependencies
`timescale 1ns / 1ps

package tsrp_pkg;

	// field widths of the message and result channels
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned DIST_W   = 32;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned SPEED_W  = 16;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned LEN_W    = 3;
	localparam int unsigned PHASE_W  = 2;

	// parse phase codes
	localparam logic [PHASE_W-1:0] PH_KEY   = 2'd0;
	localparam logic [PHASE_W-1:0] PH_VALUE = 2'd1;
	localparam logic [PHASE_W-1:0] PH_STOP  = 2'd2;

	// parse status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TRUNCATED = 2'd2;

	// keys that are captured
	localparam logic [BYTE_W-1:0] KEY_DISTANCE = 8'h01;
	localparam logic [BYTE_W-1:0] KEY_ELAPSED  = 8'h02;
	localparam logic [BYTE_W-1:0] KEY_SPEED    = 8'h21;

	// bits of the found mask
	localparam int unsigned FOUND_DIST  = 0;
	localparam int unsigned FOUND_TIME  = 1;
	localparam int unsigned FOUND_SPEED = 2;

	typedef logic [BYTE_W-1:0]   byte_t;
	typedef logic [DIST_W-1:0]   dist_t;
	typedef logic [TIME_W-1:0]   elapsed_t;
	typedef logic [SPEED_W-1:0]  speed_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [LEN_W-1:0]    len_t;
	typedef logic [PHASE_W-1:0]  phase_t;

	// one message byte handed to the parser core
	typedef struct packed {
		logic  step;
		byte_t data_byte;
		logic  last_byte;
	} step_t;

	// one result record
	typedef struct packed {
		dist_t    distance_m;
		elapsed_t elapsed_s;
		speed_t   speed_value;
		logic     distance_changed;
		logic     elapsed_changed;
		logic     speed_changed;
		status_t  parse_status;
	} result_t;

	// value length of a key in bytes, zero for an unknown key
	function automatic len_t key_length(input byte_t k);
		len_t len;
		unique case (k)
			8'h01, 8'h02:                              len = 3'd4;
			8'h03, 8'h04, 8'h05, 8'h06,
			8'h21, 8'h22, 8'h24:                       len = 3'd2;
			8'h23, 8'h25, 8'h26, 8'ha1, 8'ha2:         len = 3'd1;
			default:                                   len = 3'd0;
		endcase
		return len;
	endfunction

endpackage

/* sv/tsrp_if.sv */
// tsrp_if: valid/ready channels of the sensor record parser, one for the
// message bytes and one for the result records; depends on tsrp_pkg
`timescale 1ns / 1ps

interface tsrp_msg_if;
	logic             valid;
	logic             ready;
	tsrp_pkg::byte_t  data_byte;
	logic             last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tsrp_res_if;
	logic                valid;
	logic                ready;
	tsrp_pkg::dist_t     distance_m;
	tsrp_pkg::elapsed_t  elapsed_s;
	tsrp_pkg::speed_t    speed_value;
	logic                distance_changed;
	logic                elapsed_changed;
	logic                speed_changed;
	tsrp_pkg::status_t   parse_status;

	modport source (
		output valid, output distance_m, output elapsed_s, output speed_value,
		output distance_changed, output elapsed_changed, output speed_changed,
		output parse_status, input ready
	);
	modport sink (
		input valid, input distance_m, input elapsed_s, input speed_value,
		input distance_changed, input elapsed_changed, input speed_changed,
		input parse_status, output ready
	);
endinterface

/* sv/tsrp_record_engine.sv */
// tsrp_record_engine: parse state and stored values, one message byte per
// step; the result of a last byte is presented combinationally; uses tsrp_pkg
`timescale 1ns / 1ps

module tsrp_record_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  tsrp_pkg::step_t   item,
	output tsrp_pkg::result_t result
);
	import tsrp_pkg::*;

	phase_t   phase_q;
	len_t     bytes_left_q;
	byte_t    record_key_q;
	dist_t    value_shift_q;
	logic [2:0] found_q;
	dist_t    pend_dist_q;
	elapsed_t pend_time_q;
	speed_t   pend_speed_q;
	dist_t    stored_dist_q;
	elapsed_t stored_time_q;
	speed_t   stored_speed_q;

	phase_t   phase_n;
	len_t     bytes_left_n;
	byte_t    record_key_n;
	dist_t    value_shift_n;
	logic [2:0] found_n;
	dist_t    pend_dist_n;
	elapsed_t pend_time_n;
	speed_t   pend_speed_n;
	len_t     key_len;

	assign key_len = key_length(item.data_byte);

	// message state after this byte
	always_comb begin
		phase_n       = phase_q;
		bytes_left_n  = bytes_left_q;
		record_key_n  = record_key_q;
		value_shift_n = value_shift_q;
		found_n       = found_q;
		pend_dist_n   = pend_dist_q;
		pend_time_n   = pend_time_q;
		pend_speed_n  = pend_speed_q;
		unique case (phase_q)
			PH_KEY: begin
				if (key_len == 3'd0) begin
					phase_n = PH_STOP;
				end else begin
					record_key_n  = item.data_byte;
					bytes_left_n  = key_len;
					value_shift_n = '0;
					phase_n       = PH_VALUE;
				end
			end
			PH_VALUE: begin
				value_shift_n = {value_shift_q[DIST_W-BYTE_W-1:0], item.data_byte};
				if (bytes_left_q != 3'd0)
					bytes_left_n = bytes_left_q - 3'd1;
				if (bytes_left_n == 3'd0) begin
					phase_n = PH_KEY;
					// first complete occurrence only
					if (record_key_q == KEY_DISTANCE && !found_q[FOUND_DIST]) begin
						pend_dist_n          = value_shift_n;
						found_n[FOUND_DIST]  = 1'b1;
					end else if (record_key_q == KEY_ELAPSED && !found_q[FOUND_TIME]) begin
						pend_time_n          = value_shift_n;
						found_n[FOUND_TIME]  = 1'b1;
					end else if (record_key_q == KEY_SPEED && !found_q[FOUND_SPEED]) begin
						pend_speed_n         = value_shift_n[SPEED_W-1:0];
						found_n[FOUND_SPEED] = 1'b1;
					end
				end
			end
			default: begin
				phase_n = phase_q;
			end
		endcase
	end

	// result of a message end
	always_comb begin
		priority if (phase_n == PH_STOP)
			result.parse_status = ST_UNKNOWN;
		else if (phase_n == PH_VALUE)
			result.parse_status = ST_TRUNCATED;
		else
			result.parse_status = ST_OK;
		result.distance_m       = found_n[FOUND_DIST]  ? pend_dist_n  : stored_dist_q;
		result.elapsed_s        = found_n[FOUND_TIME]  ? pend_time_n  : stored_time_q;
		result.speed_value      = found_n[FOUND_SPEED] ? pend_speed_n : stored_speed_q;
		result.distance_changed = found_n[FOUND_DIST]  && (pend_dist_n  != stored_dist_q);
		result.elapsed_changed  = found_n[FOUND_TIME]  && (pend_time_n  != stored_time_q);
		result.speed_changed    = found_n[FOUND_SPEED] && (pend_speed_n != stored_speed_q);
	end

	// state registers, message state cleared at a last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_KEY;
			bytes_left_q   <= '0;
			record_key_q   <= '0;
			value_shift_q  <= '0;
			found_q        <= '0;
			pend_dist_q    <= '0;
			pend_time_q    <= '0;
			pend_speed_q   <= '0;
			stored_dist_q  <= '0;
			stored_time_q  <= '0;
			stored_speed_q <= '0;
		end else if (item.step) begin
			if (item.last_byte) begin
				phase_q        <= PH_KEY;
				bytes_left_q   <= '0;
				record_key_q   <= '0;
				value_shift_q  <= '0;
				found_q        <= '0;
				pend_dist_q    <= '0;
				pend_time_q    <= '0;
				pend_speed_q   <= '0;
				stored_dist_q  <= result.distance_m;
				stored_time_q  <= result.elapsed_s;
				stored_speed_q <= result.speed_value;
			end else begin
				phase_q       <= phase_n;
				bytes_left_q  <= bytes_left_n;
				record_key_q  <= record_key_n;
				value_shift_q <= value_shift_n;
				found_q       <= found_n;
				pend_dist_q   <= pend_dist_n;
				pend_time_q   <= pend_time_n;
				pend_speed_q  <= pend_speed_n;
			end
		end
	end

endmodule

/* sv/tsrp_sensor_record_parser.sv */
// tlv_sensor_record_parser: top level with input register and result register
// around the parser core; uses tsrp_pkg, tsrp_if and tsrp_record_engine
`timescale 1ns / 1ps

// Usage
//   msg: one message byte per request, last_byte marks the final byte.
//   res: one result request per message, sent after its last byte.
//   A message is a run of key/length/value records; distance, elapsed time
//   and speed are captured from their first complete record, and the stored
//   values, changed flags and parse status are sent at the message end.
// Throughput: one byte per cycle while no last byte waits on a held result,
//   set by the single pass from the input register through the parser core
//   into the result register. A last byte's result is registered there; the
//   byte waits in the input register while an earlier result is held.
// Stall: a held result blocks only a further last byte; bytes that are not
//   last keep flowing, so msg.ready drops only in that case.
// Reset: arst_n clears the parse state, stored values to zero and both
//   valid flags; no result is pending after reset.
module tlv_sensor_record_parser (
	input  logic        clk,
	input  logic        arst_n,
	tsrp_msg_if.sink    msg,
	tsrp_res_if.source  res
);
	import tsrp_pkg::*;

	logic    valid_s1;
	step_t   item_s1;
	step_t   eng_item;
	logic    consume;
	logic    res_valid_q;
	result_t res_q;
	result_t eng_result;

	// the byte in the input register goes on unless it ends a message
	// while a result is still held
	assign consume   = valid_s1 && (!item_s1.last_byte || !res_valid_q || res.ready);
	assign msg.ready = !valid_s1 || consume;

	always_comb begin
		eng_item      = item_s1;
		eng_item.step = consume;
	end

	tsrp_record_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (eng_item),
		.result (eng_result)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg.valid && msg.ready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.valid && msg.ready) begin
			item_s1.step      <= 1'b1;
			item_s1.data_byte <= msg.data_byte;
			item_s1.last_byte <= msg.last_byte;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (consume && item_s1.last_byte) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && item_s1.last_byte)
			res_q <= eng_result;
	end

	assign res.valid            = res_valid_q;
	assign res.distance_m       = res_q.distance_m;
	assign res.elapsed_s        = res_q.elapsed_s;
	assign res.speed_value      = res_q.speed_value;
	assign res.distance_changed = res_q.distance_changed;
	assign res.elapsed_changed  = res_q.elapsed_changed;
	assign res.speed_changed    = res_q.speed_changed;
	assign res.parse_status     = res_q.parse_status;

	// a message end must not overwrite a held result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && item_s1.last_byte && res_valid_q && !res.ready |-> !msg.ready)
		else $error("message end taken while a result is held");

	// a new result only follows a message end
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(consume && item_s1.last_byte))
		else $error("result raised without a message end");

	// status is one of the three codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.parse_status == ST_OK || res_q.parse_status == ST_UNKNOWN
			|| res_q.parse_status == ST_TRUNCATED))
		else $error("undefined parse status");

	// a byte that does not end a message never waits in the input register
	a_byte_flows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !item_s1.last_byte |-> consume && msg.ready)
		else $error("non-final byte stalled");

endmodule
